FILE: rtl/core/dtp_pkg.sv
// Shared constants, types and helpers of the directional thinning pass.
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

  // Default largest image size, without the zero frame.
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;

  // Image size after reset, before it is clamped to the maxima.
  localparam int unsigned DIM_RESET = 1024;

  // Configuration port geometry.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIRECTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_ROWS = 2'd2;

  // A centre is removable only with at least this many set neighbors.
  localparam int unsigned MIN_SET_NEIGH = 4;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_EAST  = 2'd3
  } dtp_dir_e;

  // Decision for one window centre.
  typedef struct packed {
    logic keep;
    logic del;
  } dtp_verdict_t;

  // Reads a written image size: zero becomes one, oversize becomes the maximum.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned x;
    x = int'(v);
    if (x < 1) x = 1;
    if (x > maxv) x = maxv;
    return x;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dtp_if.sv
// Stream interfaces for input pixels and thinned result pixels.
`timescale 1ns / 1ps
`default_nettype none

interface dtp_pixel_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface dtp_result_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic removed;
  logic frame_last;
  logic pass_removed_any;

  modport source (output valid, output pixel_out, output removed, output frame_last,
                  output pass_removed_any, input ready);
  modport sink (input valid, input pixel_out, input removed, input frame_last,
                input pass_removed_any, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dtp_line_buf.sv
// Two stacked line buffers in one memory: bit 1 is the upper line, bit 0 the middle line.
`timescale 1ns / 1ps
`default_nettype none

module dtp_line_buf #(
  parameter int unsigned Depth = dtp_pkg::MAX_COLS_DEF + 2,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [1:0]       rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [1:0]       wr_data_i
);

  logic [1:0] mem [Depth];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/dtp_col_cell.sv
// One column cell of the 3x3 window; it takes its neighbor's column on every shift.
`timescale 1ns / 1ps
`default_nettype none

module dtp_col_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [2:0] col_i,
  output logic      [2:0] col_o
);

  logic [2:0] col_q;
  logic [2:0] col_d;

  always_comb begin
    col_d = shift_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: rtl/core/dtp_decide.sv
// Removal decision for the window centre under the selected pass direction.
`timescale 1ns / 1ps
`default_nettype none

module dtp_decide (
  input  wire logic [8:0]           win_i,
  input  wire dtp_pkg::dtp_dir_e    dir_i,
  output dtp_pkg::dtp_verdict_t     verdict_o
);

  logic nw, n, ne, we, ctr, e, sw, s, se;
  logic dn;
  logic brk;
  logic [3:0] cnt;

  // Bit 3*k+r is column k (left to right) and row r (top to bottom).
  always_comb begin
    nw  = win_i[0];
    we  = win_i[1];
    sw  = win_i[2];
    n   = win_i[3];
    ctr = win_i[4];
    s   = win_i[5];
    ne  = win_i[6];
    e   = win_i[7];
    se  = win_i[8];
  end

  always_comb begin
    unique case (dir_i)
      dtp_pkg::DIR_NORTH: dn = n;
      dtp_pkg::DIR_SOUTH: dn = s;
      dtp_pkg::DIR_WEST:  dn = we;
      dtp_pkg::DIR_EAST:  dn = e;
      default:            dn = e;
    endcase
  end

  always_comb begin
    cnt = 4'({3'b0, nw}) + 4'({3'b0, n}) + 4'({3'b0, ne}) + 4'({3'b0, we})
        + 4'({3'b0, e})  + 4'({3'b0, sw}) + 4'({3'b0, s}) + 4'({3'b0, se});
    // Patterns whose removal would split the foreground locally.
    brk = (!n && !s) || (!we && !e) ||
          (!e && !s && se) || (!we && !s && sw) ||
          (!n && !e && ne) || (!we && !n && nw);
    verdict_o.del  = ctr && !dn && (cnt >= 4'(dtp_pkg::MIN_SET_NEIGH)) && !brk;
    verdict_o.keep = ctr && !verdict_o.del;
  end

endmodule

`default_nettype wire

FILE: rtl/core/directional_thinning_pass.sv
// Top level of the directional thinning pass: counters, line buffers, window chain, output.
`timescale 1ns / 1ps
`default_nettype none

// One directional thinning pass over a zero-framed binary image streamed in raster
// order, (image_rows+2) x (image_cols+2) pixels, one request per clock sustained
// while results are taken. Frame positions are read as zero whatever the host sends.
// Each request's pixel enters a three-stage path: the line buffer memory is read as
// the request is accepted, in the next stage the new column is written back and
// shifted into a chain of three column cells that forms the 3x3 window, and in the
// output stage the removal decision is registered. Only interior centres give a
// result; requests in the first two framed rows and in the first two framed
// columns give none. The result for the last interior centre carries frame_last and
// reports in pass_removed_any whether any centre of the pass was removed, after
// which the next pass may start. Each stage holds one request and passes it on as
// soon as the stage after it is free, so new requests can come in while a finished
// result waits to be taken, until the stages in front of it are full. Configuration
// is to be written only while the block is idle; the block itself does not enforce
// this. Any write to a defined register restarts the pass counters. The line buffers
// need no clearing after reset: their entries are always written before a read of
// them can reach a result.
module directional_thinning_pass #(
  parameter int unsigned MAX_COLS = dtp_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = dtp_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dtp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dtp_pkg::CFG_W-1:0]     cfg_data_i,
  dtp_pixel_if.sink                          pix_in,
  dtp_result_if.source                       res_out
);

  localparam int unsigned Depth   = MAX_COLS + 2;
  localparam int unsigned CW      = $clog2(MAX_COLS + 2);
  localparam int unsigned RW      = $clog2(MAX_ROWS + 2);
  localparam int unsigned ColsRst =
      (dtp_pkg::DIM_RESET < MAX_COLS) ? dtp_pkg::DIM_RESET : MAX_COLS;
  localparam int unsigned RowsRst =
      (dtp_pkg::DIM_RESET < MAX_ROWS) ? dtp_pkg::DIM_RESET : MAX_ROWS;

  // Configuration registers.
  dtp_pkg::dtp_dir_e dir_q;
  logic [CW-1:0]     cols_q;
  logic [RW-1:0]     rows_q;
  logic              restart;

  // Framed position of the next request.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Stage 1: line buffer read in flight.
  logic          s1_vld_q, s1_bit_q, s1_emit_q, s1_last_q, s1_rst_q;
  logic [CW-1:0] s1_addr_q;
  logic [1:0]    lb_rd;

  // Stage 2: window holds this request's neighborhood.
  logic s2_vld_q, s2_emit_q, s2_last_q, s2_rst_q;

  // Output stage and pass summary.
  logic out_vld_q, pix_out_q, rem_q, last_q, any_out_q;
  logic any_q;

  // Handshake chain.
  logic out_free, s2_adv, s2_free, s1_adv, s1_free, accept;

  // Position decode of the incoming request.
  logic [CW:0] c_ext, cols_p1, cols_p2, c_inc;
  logic [RW:0] r_ext, rows_p1;
  logic        in_frame, in_emit, in_last, in_over, in_bit;

  logic [2:0] cell_col [4];
  logic [8:0] win;
  dtp_pkg::dtp_verdict_t verdict;

  assign out_free = !out_vld_q || res_out.ready;
  assign s2_adv   = s2_vld_q && out_free;
  assign s2_free  = !s2_vld_q || s2_adv;
  assign s1_adv   = s1_vld_q && s2_free;
  assign s1_free  = !s1_vld_q || s1_adv;
  assign pix_in.ready = s1_free;
  assign accept   = pix_in.valid && s1_free;

  // Configuration writes; an undefined index changes nothing.
  always_comb begin
    case (cfg_idx_i)
      dtp_pkg::CFG_IDX_DIRECTION,
      dtp_pkg::CFG_IDX_IMAGE_COLS,
      dtp_pkg::CFG_IDX_IMAGE_ROWS: restart = cfg_we_i;
      default:                     restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= dtp_pkg::DIR_NORTH;
      cols_q <= CW'(ColsRst);
      rows_q <= RW'(RowsRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtp_pkg::CFG_IDX_DIRECTION:  dir_q  <= dtp_pkg::dtp_dir_e'(cfg_data_i[1:0]);
        dtp_pkg::CFG_IDX_IMAGE_COLS: cols_q <= CW'(dtp_pkg::clamp_dim(cfg_data_i, MAX_COLS));
        dtp_pkg::CFG_IDX_IMAGE_ROWS: rows_q <= RW'(dtp_pkg::clamp_dim(cfg_data_i, MAX_ROWS));
        default: ;
      endcase
    end
  end

  // Where the incoming request sits in the framed image.
  always_comb begin
    c_ext    = {1'b0, col_q};
    r_ext    = {1'b0, row_q};
    cols_p1  = {1'b0, cols_q} + (CW+1)'(1);
    cols_p2  = {1'b0, cols_q} + (CW+1)'(2);
    rows_p1  = {1'b0, rows_q} + (RW+1)'(1);
    c_inc    = c_ext + (CW+1)'(1);
    in_frame = (r_ext == '0) || (r_ext >= rows_p1) || (c_ext == '0) || (c_ext >= cols_p1);
    in_bit   = pix_in.pixel && !in_frame;
    in_emit  = (r_ext >= (RW+1)'(2)) && (r_ext <= rows_p1) &&
               (c_ext >= (CW+1)'(2)) && (c_ext <= cols_p1);
    in_last  = (r_ext == rows_p1) && (c_ext == cols_p1);
    in_over  = r_ext > rows_p1;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (in_last || in_over) begin
        col_d = '0;
        row_d = '0;
      end else if (c_inc >= cols_p2) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = c_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bit_q  <= in_bit;
      s1_emit_q <= in_emit;
      s1_last_q <= in_last;
      s1_rst_q  <= in_last || in_over;
      s1_addr_q <= col_q;
    end
  end

  // The upper line takes the old middle entry, the middle line the new pixel.
  dtp_line_buf #(
    .Depth (Depth),
    .AddrW (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({lb_rd[0], s1_bit_q})
  );

  // The new column enters the right cell and moves left one cell per shift.
  assign cell_col[3] = {s1_bit_q, lb_rd[0], lb_rd[1]};

  for (genvar k = 0; k < 3; k++) begin : g_cell
    dtp_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_adv),
      .col_i   (cell_col[k+1]),
      .col_o   (cell_col[k])
    );
    assign win[3*k +: 3] = cell_col[k];
  end

  // Stage 2 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      s2_rst_q  <= s1_rst_q;
    end
  end

  dtp_decide u_decide (
    .win_i     (win),
    .dir_i     (dir_q),
    .verdict_o (verdict)
  );

  // Pass summary: set by any removal, cleared when the pass ends or restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (restart) begin
      any_q <= 1'b0;
    end else if (s2_adv) begin
      if (s2_rst_q) begin
        any_q <= 1'b0;
      end else if (s2_emit_q && verdict.del) begin
        any_q <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s2_vld_q && s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      pix_out_q <= verdict.keep;
      rem_q     <= verdict.del;
      last_q    <= s2_last_q;
      any_out_q <= s2_last_q && (any_q || verdict.del);
    end
  end

  assign res_out.valid            = out_vld_q;
  assign res_out.pixel_out        = pix_out_q;
  assign res_out.removed          = rem_q;
  assign res_out.frame_last       = last_q;
  assign res_out.pass_removed_any = any_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/dtp_checker.sv
// Port-level checks on the thinning pass results, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic pixel_out_i,
  input wire logic removed_i,
  input wire logic frame_last_i,
  input wire logic pass_removed_any_i
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_out_i) &&
    $stable(removed_i) && $stable(frame_last_i) && $stable(pass_removed_any_i))
    else $error("result changed while stalled");

  // A removed centre is never also passed through.
  a_removed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && removed_i |-> !pixel_out_i)
    else $error("removed pixel still set");

  // The pass summary appears only on the final result.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pass_removed_any_i |-> frame_last_i)
    else $error("pass summary before final result");

  // A removal on the final result must show in the summary.
  a_summary_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_last_i && removed_i |-> pass_removed_any_i)
    else $error("final removal missing from summary");

endmodule

bind directional_thinning_pass dtp_checker u_dtp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (res_out.valid),
  .out_ready_i        (res_out.ready),
  .pixel_out_i        (res_out.pixel_out),
  .removed_i          (res_out.removed),
  .frame_last_i       (res_out.frame_last),
  .pass_removed_any_i (res_out.pass_removed_any)
);

`default_nettype wire
